FILE: design/fnvkt_pkg.sv
package fnvkt_pkg;

	localparam int TABLE_SLOTS   = 1024;
	localparam int MAX_ENTRIES   = 512;
	localparam int MAX_KEY_BYTES = 32;

	localparam int SLOT_W  = $clog2(TABLE_SLOTS);
	localparam int EIDX_W  = $clog2(MAX_ENTRIES);
	localparam int ECNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int KB_W    = $clog2(MAX_KEY_BYTES);
	localparam int KLEN_W  = $clog2(MAX_KEY_BYTES + 1);
	localparam int KEY_AW  = EIDX_W + KB_W;

	localparam logic [31:0] HASH_BASIS = 32'd2166136261;
	localparam logic [31:0] HASH_PRIME = 32'd16777619;

	// action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;
	localparam logic [2:0] ST_CLEARED   = 3'd5;

	// controller -> datapath
	typedef struct packed {
		logic       take_byte;
		logic       do_clear;
		logic       clr_wr;
		logic       slot_rd;
		logic       advance;
		logic       commit;
		logic       ent_rd;
		logic       key_rd;
		logic       key_next;
		logic       load;
		logic [2:0] res_st;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic olong_next;
		logic count_full;
		logic slot_valid;
		logic probe_last;
		logic len_eq;
		logic len_zero;
		logic byte_eq;
		logic byte_last;
		logic out_free;
	} sts_t;

endpackage

FILE: design/fnvkt_dp.sv
module fnvkt_dp import fnvkt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic [63:0] entry_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] found_id,
	output logic [8:0]  entry_index
);

	// storage
	logic [SLOT_W:0]   slot_mem [TABLE_SLOTS];
	logic [7:0]        key_mem  [MAX_ENTRIES * MAX_KEY_BYTES];
	logic [KLEN_W-1:0] len_mem  [MAX_ENTRIES];
	logic [63:0]       id_mem   [MAX_ENTRIES];

	logic [SLOT_W:0]   slot_rd_q;
	logic [7:0]        key_rd_q;
	logic [KLEN_W-1:0] len_rd_q;
	logic [63:0]       id_rd_q;

	logic [31:0]       hash_q;
	logic [KLEN_W-1:0] plen_q;
	logic              olong_q;
	logic [7:0]        pkey_q [MAX_KEY_BYTES];
	logic [ECNT_W-1:0] ecount_q;
	logic [SLOT_W-1:0] paddr_q;
	logic [SLOT_W-1:0] pcnt_q;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic [EIDX_W-1:0] eidx_q;
	logic [KB_W-1:0]   bidx_q;
	logic [63:0]       id_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [63:0]       found_id_q;
	logic [8:0]        entry_index_q;

	logic [31:0]       hash_next;
	logic [KB_W-1:0]   bidx_rd;
	logic              plen_room;

	// FNV-1a step
	assign hash_next = (hash_q ^ {24'd0, key_byte}) * HASH_PRIME;
	assign plen_room = (plen_q != KLEN_W'(MAX_KEY_BYTES));
	assign bidx_rd   = cmd.key_next ? bidx_q + KB_W'(1) : bidx_q;

	// status to controller
	always_comb begin
		sts.clr_last   = (clr_cnt_q == SLOT_W'(TABLE_SLOTS - 1));
		sts.olong_next = olong_q | ~plen_room;
		sts.count_full = (ecount_q == ECNT_W'(MAX_ENTRIES));
		sts.slot_valid = slot_rd_q[SLOT_W];
		sts.probe_last = (pcnt_q == SLOT_W'(TABLE_SLOTS - 1));
		sts.len_eq     = (len_rd_q == plen_q);
		sts.len_zero   = (plen_q == '0);
		sts.byte_eq    = (key_rd_q == pkey_q[bidx_q]);
		sts.byte_last  = ({1'b0, bidx_q} + KLEN_W'(1)) == plen_q;
		sts.out_free   = ~out_valid_q | out_ready;
	end

	// slot table: sweep clears, commit fills, probe reads
	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			slot_mem[clr_cnt_q] <= '0;
		else if (cmd.commit)
			slot_mem[paddr_q] <= {1'b1, {(SLOT_W-EIDX_W){1'b0}}, ecount_q[EIDX_W-1:0]};
		if (cmd.slot_rd)
			slot_rd_q <= slot_mem[paddr_q];
	end

	// key bytes are written straight into the next free entry's row
	always_ff @(posedge clk) begin
		if (cmd.take_byte && plen_room && !sts.count_full)
			key_mem[{ecount_q[EIDX_W-1:0], plen_q[KB_W-1:0]}] <= key_byte;
		if (cmd.key_rd || cmd.key_next)
			key_rd_q <= key_mem[{eidx_q, bidx_rd}];
	end

	// per-entry length and id
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			len_mem[ecount_q[EIDX_W-1:0]] <= plen_q;
			id_mem[ecount_q[EIDX_W-1:0]]  <= id_q;
		end
		if (cmd.ent_rd) begin
			len_rd_q <= len_mem[slot_rd_q[EIDX_W-1:0]];
			id_rd_q  <= id_mem[slot_rd_q[EIDX_W-1:0]];
		end
	end

	// pending key buffer and captured id
	always_ff @(posedge clk) begin
		if (cmd.take_byte && plen_room)
			pkey_q[plen_q[KB_W-1:0]] <= key_byte;
		if (cmd.take_byte && key_last)
			id_q <= entry_id;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= cmd.res_st;
			found_id_q <= (cmd.res_st == ST_FOUND) ? id_rd_q : 64'd0;
			entry_index_q <= (cmd.res_st == ST_FOUND || cmd.res_st == ST_INSERTED)
				? 9'(eidx_q) : 9'd0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= HASH_BASIS;
			plen_q      <= '0;
			olong_q     <= 1'b0;
			ecount_q    <= '0;
			paddr_q     <= '0;
			pcnt_q      <= '0;
			clr_cnt_q   <= '0;
			eidx_q      <= '0;
			bidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr)
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			if (cmd.do_clear) begin
				ecount_q <= '0;
				hash_q   <= HASH_BASIS;
				plen_q   <= '0;
				olong_q  <= 1'b0;
			end
			if (cmd.take_byte) begin
				if (plen_room)
					plen_q <= plen_q + KLEN_W'(1);
				else
					olong_q <= 1'b1;
				if (key_last) begin
					hash_q  <= HASH_BASIS;
					paddr_q <= hash_next[SLOT_W-1:0];
					pcnt_q  <= '0;
				end else begin
					hash_q <= hash_next;
				end
			end
			if (cmd.advance) begin
				paddr_q <= paddr_q + SLOT_W'(1);
				pcnt_q  <= pcnt_q + SLOT_W'(1);
			end
			if (cmd.ent_rd) begin
				eidx_q <= slot_rd_q[EIDX_W-1:0];
				bidx_q <= '0;
			end
			if (cmd.key_next)
				bidx_q <= bidx_q + KB_W'(1);
			if (cmd.commit) begin
				eidx_q   <= ecount_q[EIDX_W-1:0];
				ecount_q <= ecount_q + ECNT_W'(1);
			end
			// key done: drop pending key
			if (cmd.load) begin
				plen_q  <= '0;
				olong_q <= 1'b0;
			end
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_id    = found_id_q;
	assign entry_index = entry_index_q;

endmodule

FILE: design/fnvkt_ctrl.sv
module fnvkt_ctrl import fnvkt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic       key_last,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_PRD  = 3'd2;
	localparam logic [2:0] S_PCHK = 3'd3;
	localparam logic [2:0] S_LCHK = 3'd4;
	localparam logic [2:0] S_KCHK = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       clr_emit_q, clr_emit_d;
	logic       ins_q, ins_d;
	logic [2:0] fin_st_q, fin_st_d;
	logic       acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	// next state and commands
	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		clr_emit_d = clr_emit_q;
		ins_d      = ins_q;
		fin_st_d   = fin_st_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d  = clr_emit_q ? S_FIN : S_IDLE;
					fin_st_d = ST_CLEARED;
				end
			end
			S_IDLE: begin
				if (acc) begin
					if (action == ACT_CLEAR) begin
						cmd.do_clear = 1'b1;
						clr_emit_d   = 1'b1;
						state_d      = S_CLR;
					end else if (action == ACT_INSERT || action == ACT_LOOKUP) begin
						cmd.take_byte = 1'b1;
						ins_d = (action == ACT_INSERT);
						if (key_last) begin
							priority if (sts.olong_next) begin
								fin_st_d = ST_TOO_LONG;
								state_d  = S_FIN;
							end else if (action == ACT_INSERT && sts.count_full) begin
								fin_st_d = ST_FULL;
								state_d  = S_FIN;
							end else begin
								state_d = S_PRD;
							end
						end
					end
				end
			end
			S_PRD: begin
				cmd.slot_rd = 1'b1;
				state_d     = S_PCHK;
			end
			S_PCHK: begin
				if (!sts.slot_valid) begin
					if (ins_q) begin
						cmd.commit = 1'b1;
						fin_st_d   = ST_INSERTED;
					end else begin
						fin_st_d = ST_NOT_FOUND;
					end
					state_d = S_FIN;
				end else if (ins_q) begin
					cmd.advance = 1'b1;
					fin_st_d    = ST_FULL;
					state_d     = sts.probe_last ? S_FIN : S_PRD;
				end else begin
					cmd.ent_rd = 1'b1;
					state_d    = S_LCHK;
				end
			end
			S_LCHK: begin
				priority if (sts.len_eq && sts.len_zero) begin
					fin_st_d = ST_FOUND;
					state_d  = S_FIN;
				end else if (sts.len_eq) begin
					cmd.key_rd = 1'b1;
					state_d    = S_KCHK;
				end else begin
					cmd.advance = 1'b1;
					fin_st_d    = ST_NOT_FOUND;
					state_d     = sts.probe_last ? S_FIN : S_PRD;
				end
			end
			S_KCHK: begin
				priority if (sts.byte_eq && sts.byte_last) begin
					fin_st_d = ST_FOUND;
					state_d  = S_FIN;
				end else if (sts.byte_eq) begin
					cmd.key_next = 1'b1;
				end else begin
					cmd.advance = 1'b1;
					fin_st_d    = ST_NOT_FOUND;
					state_d     = sts.probe_last ? S_FIN : S_PRD;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load   = 1'b1;
					clr_emit_d = 1'b0;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.res_st = fin_st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_emit_q <= 1'b0;
			ins_q      <= 1'b0;
			fin_st_q   <= ST_INSERTED;
		end else begin
			state_q    <= state_d;
			clr_emit_q <= clr_emit_d;
			ins_q      <= ins_d;
			fin_st_q   <= fin_st_d;
		end
	end

endmodule

FILE: design/fnv_linear_probe_key_table.sv
// String-keyed hash table (FNV-1a, linear probing) mapping keys to 64-bit ids.
// A key byte that is not the last is taken while the controller stays idle.
// After the last byte the controller probes the slot table: an insert reads
// each probed slot and then checks it; a lookup reads and checks the slot
// and, on an occupied one, reads the stored length and id, then compares the
// key bytes one by one when the stored length matches. The result word is
// posted from the finish state once the output is free. After reset and
// after every clear the whole slot table is swept with in_ready low; a clear
// answers "cleared" at the end of its sweep. The input side stays ready for
// non-final key bytes while a result word waits on the output.
module fnv_linear_probe_key_table import fnvkt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic [63:0] entry_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] found_id,
	output logic [8:0]  entry_index
);

	cmd_t cmd;
	sts_t sts;

	fnvkt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.key_last (key_last),
		.sts      (sts),
		.cmd      (cmd)
	);

	fnvkt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.key_byte    (key_byte),
		.key_last    (key_last),
		.entry_id    (entry_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_id    (found_id),
		.entry_index (entry_index)
	);

endmodule
